>>> hw/rtl/cps_pkg.sv
// ============================================================================
// cps_pkg: shared constants and types for the contact process site update
// Reset values of the thresholds, register indexes, direction codes and the
// status flags that travel with a result beat.
// ============================================================================
`default_nettype none

package cps_pkg;

  // Lattice side length (power of two)
  localparam int SideDefault = 256;

  // Threshold registers: fractions with 16 fractional bits
  localparam int ThrWidth = 17;
  localparam logic [ThrWidth-1:0] DeathReset = 17'd39649;  // 0.605 scaled, rounded down
  localparam logic [ThrWidth-1:0] BirthReset = 17'd65536;

  // Count field width and its saturation value
  localparam int CountWidth = 17;
  localparam logic [CountWidth-1:0] CountMax = 17'h1FFFF;

  // Configuration register indexes
  localparam logic [0:0] CfgDeath = 1'b0;
  localparam logic [0:0] CfgBirth = 1'b1;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_ABOVE = 2'd2,
    DIR_BELOW = 2'd3
  } dir_e;

  typedef struct packed {
    logic new_value;
    logic changed;
    logic extinct;
  } res_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/contact_process_site_update_core.sv
// ============================================================================
// contact_process_site_update_core: one Monte Carlo step of a contact process
// Keeps a SIDE x SIDE torus of occupancy bits and the live-site count.
// ============================================================================
//
// Usage:
//  - Command channel: drive site_sel_i, direction_i and prob_draw_i and
//    raise start_i; the beat is taken at a rising edge with busy_o low.
//  - Result channel: result_valid_o strobes for one cycle with site_echo_o,
//    new_value_o, changed_o, occupied_count_o and extinct_o. There is no
//    back pressure; capture the beat in that cycle.
//  - Order: the store reads the site and its neighbor at the accept edge;
//    the evaluate cycle then decides, writes the site back and registers
//    the result, and the result strobe rises as that cycle ends. busy_o
//    covers the evaluate cycle, so no new beat is taken before the result
//    is registered and the next read always sees the last write.
//  - Reset: thresholds return to their defaults and the count to one. The
//    store is then swept once over all SIDE*SIDE sites, clearing every bit and
//    setting the centre site; busy_o stays high for the sweep. Threshold
//    writes on the config port are taken at any time, sweep included.
//  - Sites beyond the lattice keep only their low address bits.
//
// ============================================================================
`default_nettype none

module contact_process_site_update_core #(
  parameter int SIDE = cps_pkg::SideDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // command channel
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [15:0]                    site_sel_i,
  input  wire logic [1:0]                     direction_i,
  input  wire logic [15:0]                    prob_draw_i,
  // config write port
  input  wire logic                           cfg_we_i,
  input  wire logic [0:0]                     cfg_index_i,
  input  wire logic [cps_pkg::ThrWidth-1:0]   cfg_wdata_i,
  // result channel
  output logic                                result_valid_o,
  output logic [15:0]                         site_echo_o,
  output logic                                new_value_o,
  output logic                                changed_o,
  output logic [cps_pkg::CountWidth-1:0]      occupied_count_o,
  output logic                                extinct_o
);

  localparam int AW = 2 * $clog2(SIDE);

  logic [cps_pkg::ThrWidth-1:0] death_q, birth_q;

  logic [AW-1:0] site_addr, nbr_addr, waddr;
  logic          accept, we, wdata, rd_site, rd_nbr;
  cps_pkg::res_flags_t flags;

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      death_q <= cps_pkg::DeathReset;
      birth_q <= cps_pkg::BirthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cps_pkg::CfgDeath: death_q <= cfg_wdata_i;
        cps_pkg::CfgBirth: birth_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Reduce the site to the lattice address range
  assign site_addr = AW'(site_sel_i);

  cps_neighbor #(.SIDE(SIDE)) u_nbr (
    .site_i (site_addr),
    .dir_i  (direction_i),
    .nbr_o  (nbr_addr)
  );

  cps_lattice_mem #(.AW(AW)) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (accept),
    .raddr_a_i (site_addr),
    .raddr_b_i (nbr_addr),
    .rdata_a_o (rd_site),
    .rdata_b_o (rd_nbr)
  );

  cps_update #(.SIDE(SIDE)) u_upd (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .site_i         (site_addr),
    .draw_i         (prob_draw_i),
    .death_thr_i    (death_q),
    .birth_thr_i    (birth_q),
    .rd_site_i      (rd_site),
    .rd_nbr_i       (rd_nbr),
    .accept_o       (accept),
    .busy_o         (busy_o),
    .mem_we_o       (we),
    .mem_waddr_o    (waddr),
    .mem_wdata_o    (wdata),
    .result_valid_o (result_valid_o),
    .site_echo_o    (site_echo_o),
    .count_o        (occupied_count_o),
    .flags_o        (flags)
  );

  assign new_value_o = flags.new_value;
  assign changed_o   = flags.changed;
  assign extinct_o   = flags.extinct;

endmodule

`default_nettype wire

>>> hw/rtl/cps_lattice_mem.sv
// ============================================================================
// cps_lattice_mem: occupancy bit store
// One write port and two registered read ports, read enabled by re_i.
// ============================================================================
`default_nettype none

module cps_lattice_mem #(
  parameter int AW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic          wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_a_i,
  input  wire logic [AW-1:0] raddr_b_i,
  output logic               rdata_a_o,
  output logic               rdata_b_o
);

  localparam int Depth = 1 << AW;

  logic mem [Depth];
  logic rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

>>> hw/rtl/cps_neighbor.sv
// ============================================================================
// cps_neighbor: torus neighbor address
// Step one column or row in the given direction, wrapping at the edges.
// ============================================================================
`default_nettype none

module cps_neighbor #(
  parameter int SIDE = cps_pkg::SideDefault
) (
  input  wire logic [2*$clog2(SIDE)-1:0] site_i,
  input  wire logic [1:0]                dir_i,
  output logic      [2*$clog2(SIDE)-1:0] nbr_o
);

  localparam int LW = $clog2(SIDE);

  logic [LW-1:0] x, y, x_n, y_n;

  assign x = site_i[LW-1:0];
  assign y = site_i[2*LW-1:LW];

  always_comb begin
    x_n = x;
    y_n = y;
    unique case (cps_pkg::dir_e'(dir_i))
      cps_pkg::DIR_LEFT:  x_n = x - LW'(1);
      cps_pkg::DIR_RIGHT: x_n = x + LW'(1);
      cps_pkg::DIR_ABOVE: y_n = y - LW'(1);
      cps_pkg::DIR_BELOW: y_n = y + LW'(1);
      default: ;
    endcase
  end

  assign nbr_o = {y_n, x_n};

endmodule

`default_nettype wire

>>> hw/rtl/cps_update.sv
// ============================================================================
// cps_update: sequencer and update logic
// Clear pass after reset, then per beat: read, decide, write back, report.
// ============================================================================
`default_nettype none

module cps_update #(
  parameter int SIDE = cps_pkg::SideDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [2*$clog2(SIDE)-1:0]         site_i,
  input  wire logic [15:0]                       draw_i,
  input  wire logic [cps_pkg::ThrWidth-1:0]      death_thr_i,
  input  wire logic [cps_pkg::ThrWidth-1:0]      birth_thr_i,
  input  wire logic                              rd_site_i,
  input  wire logic                              rd_nbr_i,
  output logic                                   accept_o,
  output logic                                   busy_o,
  output logic                                   mem_we_o,
  output logic      [2*$clog2(SIDE)-1:0]         mem_waddr_o,
  output logic                                   mem_wdata_o,
  output logic                                   result_valid_o,
  output logic      [15:0]                       site_echo_o,
  output logic      [cps_pkg::CountWidth-1:0]    count_o,
  output cps_pkg::res_flags_t                    flags_o
);

  localparam int AW    = 2 * $clog2(SIDE);
  localparam int Cells = SIDE * SIDE;
  localparam int CW    = AW + 1;
  localparam int XW    = (CW > cps_pkg::CountWidth) ? CW : cps_pkg::CountWidth;
  localparam logic [AW-1:0] Centre = AW'(Cells / 2 + SIDE / 2);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EVAL  = 3'b100
  } state_e;

  state_e  state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          valid_q;
  logic [AW-1:0] site_q;
  logic [15:0]   draw_q;
  logic [15:0]   echo_q;
  logic [cps_pkg::CountWidth-1:0] count_q;
  cps_pkg::res_flags_t flags_q;

  logic          now, changed;
  logic [XW-1:0] cnt_x;
  logic [cps_pkg::CountWidth-1:0] cnt_sat;

  assign accept_o = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q != ST_IDLE);

  // Decide the new occupancy from the registered memory reads
  always_comb begin
    if (rd_site_i) begin
      now = !({1'b0, draw_q} < death_thr_i);
    end else begin
      now = rd_nbr_i && ({1'b0, draw_q} < birth_thr_i);
    end
    changed = now ^ rd_site_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if ((state_q == ST_EVAL) && changed) begin
      if (now) begin
        cnt_d = cnt_q + CW'(1);
      end else if (cnt_q != '0) begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  assign cnt_x   = XW'(cnt_d);
  assign cnt_sat = (cnt_x > XW'(cps_pkg::CountMax)) ? cps_pkg::CountMax
                                                    : cps_pkg::CountWidth'(cnt_x);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = site_q;
    mem_wdata_o = now;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = (clr_q == Centre);
        clr_d       = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        mem_we_o = changed;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= CW'(1);
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      valid_q <= (state_q == ST_EVAL);
    end
  end

  // Payload: capture on accept, report at the end of the evaluate cycle
  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      site_q <= site_i;
      draw_q <= draw_i;
    end
    if (state_q == ST_EVAL) begin
      echo_q            <= 16'(site_q);
      count_q           <= cnt_sat;
      flags_q.new_value <= now;
      flags_q.changed   <= changed;
      flags_q.extinct   <= (cnt_d == '0);
    end
  end

  assign result_valid_o = valid_q;
  assign site_echo_o    = echo_q;
  assign count_o        = count_q;
  assign flags_o        = flags_q;

endmodule

`default_nettype wire

>>> hw/rtl/cps_checker.sv
// ============================================================================
// cps_checker: port-level checks for the site update core
// Timing of accept and result beats and consistency of the result fields.
// ============================================================================
`default_nettype none

module cps_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        result_valid_o,
  input wire logic        new_value_o,
  input wire logic        changed_o,
  input wire logic [16:0] occupied_count_o,
  input wire logic        extinct_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  // An accepted beat yields its result once its evaluate cycle ends
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 result_valid_o)
    else $error("result beat missing two cycles after accept");

  // Hold busy and no result in the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o && !result_valid_o))
    else $error("busy or result wrong in the evaluate cycle");

  // Result strobes never come back to back
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // Extinction matches an empty count
  a_extinct_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (extinct_o == (occupied_count_o == 17'd0)))
    else $error("extinct flag disagrees with occupied count");

  // A site that just became occupied leaves the lattice alive
  a_birth_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && changed_o && new_value_o) |-> !extinct_o)
    else $error("extinct reported after a birth");

endmodule

bind contact_process_site_update_core cps_checker u_cps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .result_valid_o   (result_valid_o),
  .new_value_o      (new_value_o),
  .changed_o        (changed_o),
  .occupied_count_o (occupied_count_o),
  .extinct_o        (extinct_o)
);

`default_nettype wire

>>> dv/contact_process_site_update_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// contact_process_site_update_core_tb: self-checking bench for the site update
// Drives site update commands, with directed rules first, then edge wraparound,
// random well-formed growth and decay, and finally a full extinction sweep.
// A local lattice predictor computes each result beat, and a monitor compares
// every strobed result field by field against the oldest pending prediction.
// ============================================================================

module contact_process_site_update_core_tb;
  import cps_pkg::*;

  localparam int          Side       = SideDefault;
  localparam int unsigned Cells      = Side * Side;
  localparam int unsigned Centre     = Cells / 2 + Side / 2;
  localparam int unsigned FullScale  = 65536;
  localparam int unsigned CycleLimit = 500000;

  // One predicted result beat
  typedef struct packed {
    logic [15:0]           site;
    res_flags_t            flags;
    logic [CountWidth-1:0] count;
  } site_result_t;

  // DUT connections
  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [15:0]           site_sel;
  dir_e                  direction;
  logic [15:0]           prob_draw;
  logic                  cfg_we;
  logic [0:0]            cfg_index;
  logic [ThrWidth-1:0]   cfg_wdata;
  logic                  result_valid;
  logic [15:0]           site_echo;
  logic                  new_value;
  logic                  changed;
  logic [CountWidth-1:0] occupied_count;
  logic                  extinct;

  // Lattice predictor state
  bit                    occ_map [Cells];
  int unsigned           live_sites;
  logic [ThrWidth-1:0]   death_thr;
  logic [ThrWidth-1:0]   birth_thr;
  int unsigned           born_pool[$];   // every site ever filled, may hold stale entries

  // Scoreboard
  site_result_t          pending_updates_q[$];
  int unsigned           errors;
  int unsigned           sent_cnt;
  int unsigned           checked_cnt;
  int unsigned           births;
  int unsigned           deaths;
  int unsigned           cycle_cnt;
  logic                  idle_en;

  contact_process_site_update_core #(
    .SIDE (Side)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .site_sel_i       (site_sel),
    .direction_i      (direction),
    .prob_draw_i      (prob_draw),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .result_valid_o   (result_valid),
    .site_echo_o      (site_echo),
    .new_value_o      (new_value),
    .changed_o        (changed),
    .occupied_count_o (occupied_count),
    .extinct_o        (extinct)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Neighbor of a site on the torus; wrap both axes
  function automatic int unsigned step_site(int unsigned site, dir_e dir);
    int unsigned x;
    int unsigned y;
    x = site % Side;
    y = (site / Side) % Side;
    case (dir)
      DIR_LEFT:  x = (x + Side - 1) % Side;
      DIR_RIGHT: x = (x + 1) % Side;
      DIR_ABOVE: y = (y + Side - 1) % Side;
      default:   y = (y + 1) % Side;
    endcase
    return (y * Side + x) % Cells;
  endfunction

  // Direction that points back to where a step came from
  function automatic dir_e back_dir(dir_e dir);
    case (dir)
      DIR_LEFT:  return DIR_RIGHT;
      DIR_RIGHT: return DIR_LEFT;
      DIR_ABOVE: return DIR_BELOW;
      default:   return DIR_ABOVE;
    endcase
  endfunction

  // Apply one update to the local lattice and return the beat it must produce
  function automatic site_result_t predict_site_update(logic [15:0] site_in, dir_e dir,
                                                       logic [15:0] draw);
    int unsigned  site;
    bit           was;
    bit           now;
    site_result_t res;
    site = site_in % Cells;   // drop address bits beyond the lattice
    was  = occ_map[site];
    now  = was;
    if (was) begin
      if ({1'b0, draw} < death_thr) now = 1'b0;
    end else if (occ_map[step_site(site, dir)] && ({1'b0, draw} < birth_thr)) begin
      now = 1'b1;
    end
    if (now != was) begin
      occ_map[site] = now;
      if (now) begin
        live_sites++;
        births++;
        born_pool.push_back(site);
      end else if (live_sites > 0) begin
        live_sites--;
        deaths++;
      end
    end
    res.site            = site[15:0];
    res.flags.new_value = now;
    res.flags.changed   = (now != was);
    res.flags.extinct   = (live_sites == 0);
    // saturate the reported count, keep the flag on the exact one
    res.count = (live_sites > CountMax) ? CountMax : live_sites[CountWidth-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  // Pop the oldest prediction on every strobed beat
  always @(posedge clk) begin : result_check
    site_result_t want;
    if (rst_n && result_valid) begin
      if (pending_updates_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending, expected none actual site %0d",
                 $time, site_echo);
      end else begin
        want = pending_updates_q.pop_front();
        check_field("site_echo", want.site, site_echo);
        check_field("new_value", want.flags.new_value, new_value);
        check_field("changed", want.flags.changed, changed);
        check_field("occupied_count", want.count, occupied_count);
        check_field("extinct", want.flags.extinct, extinct);
        checked_cnt++;
      end
    end
  end

  // Watchdog: the reset sweep alone visits all Cells sites
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: watchdog expired with %0d beats pending", $time,
               pending_updates_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers; every task is entered and left at a falling edge
  // --------------------------------------------------------------------------

  // Send one command beat, hold it until busy drops, then predict
  task automatic send_update(input int unsigned site, input dir_e dir,
                             input int unsigned draw);
    if (idle_en && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(negedge clk);
    start      = 1'b1;
    site_sel   = site[15:0];
    direction  = dir;
    prob_draw  = draw[15:0];
    do @(posedge clk); while (busy);
    pending_updates_q.push_back(predict_site_update(site_sel, direction, prob_draw));
    sent_cnt++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Wait for every pending beat, then a few cycles of margin
  task automatic drain_results();
    while (pending_updates_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Threshold write; only issued with the core idle
  task automatic write_threshold(input logic [0:0] idx, input int unsigned value);
    drain_results();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[ThrWidth-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CfgDeath) death_thr = value[ThrWidth-1:0];
    else                 birth_thr = value[ThrWidth-1:0];
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Update rules around the centre site, threshold boundaries and extremes
  task automatic test_directed_rules();
    // default thresholds: draws at or above the death threshold keep the site
    send_update(Centre, DIR_LEFT, 16'hFFFF);
    send_update(Centre, DIR_RIGHT, DeathReset);
    write_threshold(CfgDeath, 0);
    send_update(Centre, DIR_ABOVE, 0);
    // full-scale birth: fill each neighbor of the centre from its own side
    send_update(Centre - 1, DIR_RIGHT, 16'hFFFF);
    send_update(Centre + 1, DIR_LEFT, $urandom_range(0, 65535));
    send_update(Centre - Side, DIR_BELOW, $urandom_range(0, 65535));
    send_update(Centre + Side, DIR_ABOVE, $urandom_range(0, 65535));
    // empty site looking the wrong way stays empty
    send_update(Centre - 2, DIR_LEFT, 0);
    // zero birth threshold blocks even the lowest draw
    write_threshold(CfgBirth, 0);
    send_update(Centre + 2, DIR_LEFT, 0);
    // draw equal to the threshold fails, one below succeeds
    write_threshold(CfgBirth, 1000);
    send_update(Centre + 2, DIR_LEFT, 1000);
    send_update(Centre + 2, DIR_LEFT, 999);
    // full-scale death clears on the highest draw
    write_threshold(CfgDeath, FullScale);
    send_update(Centre + 2, DIR_BELOW, 16'hFFFF);
    write_threshold(CfgDeath, 500);
    send_update(Centre + 1, DIR_ABOVE, 500);
    send_update(Centre + 1, DIR_ABOVE, 499);
    // lowest and highest site index, both with empty neighbors
    send_update(0, DIR_LEFT, 0);
    send_update(Cells - 1, DIR_RIGHT, 16'hFFFF);
  endtask

  // Grow lines out to the lattice edges and cross each edge both ways
  task automatic test_wraparound();
    int unsigned cur;
    int unsigned across;
    write_threshold(CfgDeath, 0);
    write_threshold(CfgBirth, FullScale);
    // centre row out to the last column
    cur = Centre;
    repeat (Side / 2 - 1) begin
      cur = step_site(cur, DIR_RIGHT);
      send_update(cur, DIR_LEFT, $urandom_range(0, 65535));
    end
    // first column fills from the last one through the left edge
    across = step_site(cur, DIR_RIGHT);
    send_update(across, DIR_LEFT, $urandom_range(0, 65535));
    // clear the last column, refill it through the right edge
    write_threshold(CfgDeath, FullScale);
    send_update(cur, DIR_LEFT, $urandom_range(0, 65535));
    write_threshold(CfgDeath, 0);
    send_update(cur, DIR_RIGHT, $urandom_range(0, 65535));
    // centre column up to the top row
    cur = Centre;
    repeat (Side / 2) begin
      cur = step_site(cur, DIR_ABOVE);
      send_update(cur, DIR_BELOW, $urandom_range(0, 65535));
    end
    // bottom row fills from the top one, then the reverse
    across = step_site(cur, DIR_ABOVE);
    send_update(across, DIR_BELOW, $urandom_range(0, 65535));
    write_threshold(CfgDeath, FullScale);
    send_update(cur, DIR_BELOW, $urandom_range(0, 65535));
    write_threshold(CfgDeath, 0);
    send_update(cur, DIR_ABOVE, $urandom_range(0, 65535));
  endtask

  // One random command, mostly aimed at the live cluster
  task automatic random_update();
    int unsigned anchor;
    int unsigned cand;
    int unsigned site;
    int unsigned thr;
    int unsigned draw;
    int unsigned pick;
    dir_e        dir;
    // find a live anchor; stale pool entries are skipped
    anchor = Centre;
    for (int i = 0; i < 8; i++) begin
      cand = born_pool[$urandom_range(0, born_pool.size() - 1)];
      if (occ_map[cand]) begin
        anchor = cand;
        break;
      end
    end
    dir  = dir_e'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 15)                         site = $urandom_range(0, 65535);  // noise
    else if (pick < 50 && live_sites > 2)  site = anchor;                    // try a death
    else                                   site = step_site(anchor, back_dir(dir));
    // bias the draw toward the threshold that applies
    thr = occ_map[site % Cells] ? death_thr : birth_thr;
    case ($urandom_range(0, 7))
      0:       draw = (thr == 0) ? 0 : thr - 1;
      1:       draw = thr;
      2:       draw = 0;
      3:       draw = 65535;
      default: draw = $urandom_range(0, 65535);
    endcase
    if (draw > 65535) draw = 65535;
    send_update(site, dir, draw);
  endtask

  // Phases of random traffic under different threshold pairs
  task automatic test_random_updates();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_threshold(CfgDeath, DeathReset);
          write_threshold(CfgBirth, BirthReset);
        end
        1: begin
          write_threshold(CfgDeath, 0);
          write_threshold(CfgBirth, FullScale);
        end
        2: begin
          write_threshold(CfgDeath, $urandom_range(0, FullScale));
          write_threshold(CfgBirth, $urandom_range(0, FullScale));
        end
        3: begin
          write_threshold(CfgDeath, FullScale);
          write_threshold(CfgBirth, FullScale);
        end
        default: begin
          // final stretch runs back to back
          idle_en = 1'b0;
          write_threshold(CfgDeath, $urandom_range(0, FullScale));
          write_threshold(CfgBirth, $urandom_range(40000, FullScale));
        end
      endcase
      repeat (20) random_update();
    end
  endtask

  // Clear every live site, then confirm nothing can grow back
  task automatic test_extinction();
    write_threshold(CfgDeath, FullScale);
    write_threshold(CfgBirth, 0);
    for (int i = 0; i < born_pool.size(); i++) begin
      if (occ_map[born_pool[i]])
        send_update(born_pool[i], dir_e'($urandom_range(0, 3)), $urandom_range(0, 65535));
    end
    write_threshold(CfgBirth, FullScale);
    repeat (8) send_update($urandom_range(0, 65535), dir_e'($urandom_range(0, 3)), 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    site_sel   = '0;
    direction  = DIR_LEFT;
    prob_draw  = '0;
    cfg_we     = 1'b0;
    cfg_index  = CfgDeath;
    cfg_wdata  = '0;
    idle_en    = 1'b1;
    errors     = 0;
    sent_cnt   = 0;
    checked_cnt = 0;
    births     = 0;
    deaths     = 0;
    cycle_cnt  = 0;

    // predictor starts from the reset lattice: only the centre is occupied
    occ_map[Centre] = 1'b1;
    live_sites      = 1;
    death_thr       = DeathReset;
    birth_thr       = BirthReset;
    born_pool.push_back(Centre);

    // hold reset low, then release it on a falling edge
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_directed_rules();
    test_wraparound();
    test_random_updates();
    test_extinction();
    drain_results();
    repeat (8) @(negedge clk);

    $display("Sent %0d site updates and checked %0d result beats (%0d births, %0d deaths).",
             sent_cnt, checked_cnt, births, deaths);
    $display("Covered threshold extremes, both edge wraps and a lattice driven extinct.");
    if (errors == 0 && pending_updates_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
